### rtl/gcgb_pkg.sv
// Shared types and constants for the glyph coverage gamma blend pipeline.
package gcgb_pkg;

    // Pipeline depth: two product stages, one stage per root bit, three scale stages.
    localparam int unsigned ROOT_BITS = 17;
    localparam int unsigned STAGES    = 2 + ROOT_BITS + 3;

    // Root search works on N * 2^32 against r^2 * 255^3.
    localparam int unsigned REM_W  = 58;
    localparam int unsigned TSUM_W = 42;
    localparam int unsigned LIN_FRAC_BITS = 32;
    localparam logic [TSUM_W-1:0] CUBE_255 = TSUM_W'(64'd16581375);

    // Output scale: floor(R * 255999 / (1000 * 2^16)).
    localparam logic [17:0] SCALE_NUM  = 18'd255999;
    // ceil(2^28 / 1000), exact for dividends below 493447.
    localparam logic [18:0] RECIP_1000 = 19'd268436;
    localparam int unsigned RECIP_SHIFT = 28;

    localparam logic [7:0] BYTE_MAX = 8'hFF;

    typedef logic [7:0]          byte_t;
    typedef logic [REM_W-1:0]    rem_t;
    typedef logic [TSUM_W-1:0]   tsum_t;
    typedef logic [ROOT_BITS-1:0] root_t;
    typedef logic [STAGES-1:0]   stage_en_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TEXT_RED   = 2'd0,
        CFG_TEXT_GREEN = 2'd1,
        CFG_TEXT_BLUE  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

endpackage

### rtl/gcgb_ctrl.sv
// Valid/ready control for the blend pipeline, one valid bit per stage.
module gcgb_ctrl
    import gcgb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output stage_en_t stage_en
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   ready;

    // A stage loads when it is empty or its successor takes its content.
    always_comb begin
        ready[STAGES] = m_tready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb begin
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            if (ready[i]) begin
                valid_next[i] = valid_reg[i-1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign stage_en = ready[STAGES-1:0];
    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[STAGES-1];

endmodule

### rtl/gcgb_sqrt_step.sv
// One bit of the restoring root search: largest r with r^2 * 255^3 <= N * 2^32.
module gcgb_sqrt_step
    import gcgb_pkg::*;
#(
    parameter int unsigned K = 0
) (
    input  logic  aclk,
    input  logic  en,
    input  rem_t  rem_in,
    input  tsum_t tsum_in,
    input  root_t root_in,
    output rem_t  rem_reg,
    output tsum_t tsum_reg,
    output root_t root_reg
);

    // tsum holds 2 * r * 255^3; trial is the growth of r^2 * 255^3 when bit K is set.
    localparam tsum_t CS  = CUBE_255 << K;
    localparam tsum_t CS2 = CUBE_255 << (K + 1);
    localparam root_t BIT = root_t'(1) << K;

    tsum_t tx;
    rem_t  trial;
    rem_t  rem_next;
    tsum_t tsum_next;
    root_t root_next;

    always_comb begin
        tx    = tsum_in + CS;
        trial = rem_t'(tx) << K;
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            tsum_next = tsum_in + CS2;
            root_next = root_in | BIT;
        end else begin
            rem_next  = rem_in;
            tsum_next = tsum_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            tsum_reg <= tsum_next;
            root_reg <= root_next;
        end
    end

endmodule

### rtl/gcgb_channel.sv
// One color channel: linear blend numerator, root search and output scaling.
module gcgb_channel
    import gcgb_pkg::*;
(
    input  logic      aclk,
    input  stage_en_t stage_en,
    input  byte_t     text,
    input  byte_t     cov,
    input  byte_t     dest,
    output byte_t     out_reg
);

    // stage 0: products
    logic [15:0] tc_reg;
    logic [15:0] dd_reg;
    byte_t       inv_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            tc_reg  <= text * cov;
            dd_reg  <= dest * dest;
            inv_reg <= BYTE_MAX - cov;
        end
    end

    // stage 1: N = t*cov*255 + d^2*(255-cov), at most 255^3
    logic [23:0] tc255;
    logic [23:0] ddinv;
    logic [23:0] n_reg;

    always_comb begin
        tc255 = {tc_reg, 8'b0} - {8'b0, tc_reg};
        ddinv = {8'b0, dd_reg} * {16'b0, inv_reg};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            n_reg <= tc255 + ddinv;
        end
    end

    // stages 2..18: root, MSB first
    rem_t  rem_s  [ROOT_BITS+1];
    tsum_t tsum_s [ROOT_BITS+1];
    root_t root_s [ROOT_BITS+1];

    assign rem_s[0]  = rem_t'({n_reg, {LIN_FRAC_BITS{1'b0}}});
    assign tsum_s[0] = '0;
    assign root_s[0] = '0;

    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
        gcgb_sqrt_step #(
            .K(ROOT_BITS - 1 - j)
        ) u_step (
            .aclk     (aclk),
            .en       (stage_en[2+j]),
            .rem_in   (rem_s[j]),
            .tsum_in  (tsum_s[j]),
            .root_in  (root_s[j]),
            .rem_reg  (rem_s[j+1]),
            .tsum_reg (tsum_s[j+1]),
            .root_reg (root_s[j+1])
        );
    end

    // stages 19..21: floor(R * 255999 / 2^16) then divide by 1000 via reciprocal
    logic [34:0] p_reg;
    logic [36:0] y_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[ROOT_BITS+2]) begin
            p_reg <= root_s[ROOT_BITS] * SCALE_NUM;
        end
        if (stage_en[ROOT_BITS+3]) begin
            y_reg <= p_reg[33:16] * RECIP_1000;
        end
        if (stage_en[ROOT_BITS+4]) begin
            out_reg <= y_reg[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

endmodule

### rtl/glyph_coverage_gamma_blend.sv
// Top level of the glyph coverage gamma blend: config registers, three channels, control.
//
//  channel   | ports                         | tdata fields, low bit up
//  ----------+-------------------------------+-------------------------------------------
//  input     | s_tvalid s_tready s_tdata[39:0] | coverage, dest_red, dest_green, dest_blue,
//            |                               | dest_alpha (8 bits each)
//  result    | m_tvalid m_tready m_tdata[31:0] | out_red, out_green, out_blue, out_alpha
//  config    | cfg_we cfg_index cfg_wdata     | text_red, text_green, text_blue (index 0..2)
//
// One request per clock sustained while m_tready is high.
// Depth is set by the bit-serial root search: one stage per root bit (17),
// plus two product stages and three output scaling stages.
// Every stage carries a valid bit; a stage loads whenever it is empty or its
// successor moves, so bubbles close up and a stalled result holds its place.
// aresetn is synchronous, active low; it clears valid bits, sets text color to white.
// Config must be written only while the pipeline is empty; the block does not check.
module glyph_coverage_gamma_blend
    import gcgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // coverage, dest_red, dest_green, dest_blue, dest_alpha
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    // config write
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    stage_en_t stage_en;

    gcgb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stage_en (stage_en)
    );

    // text color registers; index 3 is ignored
    byte_t text_red_reg,   text_red_next;
    byte_t text_green_reg, text_green_next;
    byte_t text_blue_reg,  text_blue_next;

    always_comb begin
        text_red_next   = text_red_reg;
        text_green_next = text_green_reg;
        text_blue_next  = text_blue_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TEXT_RED:   text_red_next   = cfg_wdata;
                CFG_TEXT_GREEN: text_green_next = cfg_wdata;
                CFG_TEXT_BLUE:  text_blue_next  = cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_red_reg   <= BYTE_MAX;
            text_green_reg <= BYTE_MAX;
            text_blue_reg  <= BYTE_MAX;
        end else begin
            text_red_reg   <= text_red_next;
            text_green_reg <= text_green_next;
            text_blue_reg  <= text_blue_next;
        end
    end

    // unpack the request
    byte_t coverage, dest_red, dest_green, dest_blue, dest_alpha;

    assign coverage   = s_tdata[7:0];
    assign dest_red   = s_tdata[15:8];
    assign dest_green = s_tdata[23:16];
    assign dest_blue  = s_tdata[31:24];
    assign dest_alpha = s_tdata[39:32];

    byte_t out_red, out_green, out_blue;

    gcgb_channel u_red (
        .aclk     (aclk),
        .stage_en (stage_en),
        .text     (text_red_reg),
        .cov      (coverage),
        .dest     (dest_red),
        .out_reg  (out_red)
    );

    gcgb_channel u_green (
        .aclk     (aclk),
        .stage_en (stage_en),
        .text     (text_green_reg),
        .cov      (coverage),
        .dest     (dest_green),
        .out_reg  (out_green)
    );

    gcgb_channel u_blue (
        .aclk     (aclk),
        .stage_en (stage_en),
        .text     (text_blue_reg),
        .cov      (coverage),
        .dest     (dest_blue),
        .out_reg  (out_blue)
    );

    // alpha rides along the pipeline untouched
    byte_t alpha_reg [STAGES];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            alpha_reg[0] <= dest_alpha;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    assign m_tdata = {alpha_reg[STAGES-1], out_blue, out_green, out_red};

endmodule
